/* rtl/tspcr_pkg.sv */
// ----------------------------------------------------------------------------
// tspcr_pkg: shared types and constants of the PCR stamp generator
// Field widths, the fixed clock multiplier and the stage record layouts.
// ----------------------------------------------------------------------------
package tspcr_pkg;

   localparam int POS_W  = 36;   // byte position
   localparam int CC_W   = 4;    // continuity counter
   localparam int RATE_W = 31;   // bit rate register
   localparam int A_W    = 37;   // byte position plus packet offset
   localparam int LO_W   = 60;   // low partial product, 32 x 28 bits
   localparam int HI_W   = 33;   // high partial product, 5 x 28 bits
   localparam int P_W    = 65;   // full product
   localparam int D_W    = 40;   // bit rate times 300
   localparam int Q_W    = 57;   // clock value divided by 300
   localparam int E_W    = 9;    // extension
   localparam int BASE_W = 33;
   localparam int PF_W   = 48;
   localparam int HB_W   = 8;

   localparam int PRE_STAGES = 3;
   localparam int DIV1_STEPS = Q_W;
   localparam int DIV2_STEPS = E_W;

   // 8 bits per byte times the 27 MHz system clock
   localparam logic [27:0]       PCR_MUL      = 28'd216000000;
   localparam logic [3:0]        POS_OFFSET   = 4'd10;
   localparam logic [E_W-1:0]    EXT_DIV      = 9'd300;
   localparam logic [5:0]        RSV_BITS     = 6'h3F;
   localparam logic [3:0]        ADAPT_NIBBLE = 4'h2;
   localparam logic [CC_W-1:0]   CC_STEP      = 4'd1;

   // first divider: product / (rate * 300), one quotient bit per stage
   typedef struct packed {
      logic [D_W-1:0]  rem;
      logic [Q_W-1:0]  dq;    // dividend bits shift out, quotient bits shift in
      logic [CC_W-1:0] cc;
   } div1_type;

   // second divider: remainder / rate gives the extension
   typedef struct packed {
      logic [RATE_W-1:0] rem;
      logic [E_W-1:0]    dq;
      logic [Q_W-1:0]    clk_div;
      logic [CC_W-1:0]   cc;
   } div2_type;

   typedef struct packed {
      logic [BASE_W-1:0] clock_base;
      logic [E_W-1:0]    clock_extension;
      logic [PF_W-1:0]   packed_field;
      logic [HB_W-1:0]   header_byte;
      logic [CC_W-1:0]   next_continuity;
      logic              clock_wrapped;
   } result_type;

endpackage

/* rtl/ts_pcr_stamp_generator.sv */
// ----------------------------------------------------------------------------
// ts_pcr_stamp_generator: transport stream PCR stamp generator
// Turns a byte position into a 27 MHz PCR (base, extension, packed
// adaptation-field bytes) and forms header byte 3 and the next continuity
// count.
// ----------------------------------------------------------------------------
// Usage
//   Request channel (req_*): byte position and continuity count, taken when
//   req_valid and req_ready are both high. Response channel (rsp_*): one
//   result per request, in request order, held until rsp_ready.
//   csr_wen/csr_wdata write the stream bit rate (a value of zero acts as 1);
//   write it only while no request is in flight.
//   Path: a result reaches rsp_valid through these registers in order:
//   the request edge loads the offset add, then two partial products, their
//   sum, 57 restoring steps of product / (rate * 300), 9 restoring steps of
//   remainder / rate, and the output register.
//   Throughput: one request per cycle while req_ready is high, set by the
//   one-bit-per-stage divider pipeline; every stage advances together.
//   Stall: a held result does not stop the pipeline; the next arriving
//   result parks in a skid register, and only when that is full does
//   req_ready drop and the whole pipeline freeze.
//   Reset: clears all valid bits and sets the bit rate to 1.
// ----------------------------------------------------------------------------
module ts_pcr_stamp_generator (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [tspcr_pkg::POS_W-1:0]   req_byte_position,
   input  logic [tspcr_pkg::CC_W-1:0]    req_continuity_count,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [tspcr_pkg::BASE_W-1:0]  rsp_clock_base,
   output logic [tspcr_pkg::E_W-1:0]     rsp_clock_extension,
   output logic [tspcr_pkg::PF_W-1:0]    rsp_packed_field,
   output logic [tspcr_pkg::HB_W-1:0]    rsp_header_byte,
   output logic [tspcr_pkg::CC_W-1:0]    rsp_next_continuity,
   output logic                          rsp_clock_wrapped,
   input  logic                          csr_wen,
   input  logic [tspcr_pkg::RATE_W-1:0]  csr_wdata
);
   import tspcr_pkg::*;

   localparam int NSTG = PRE_STAGES + DIV1_STEPS + DIV2_STEPS;

   // ------------------------------------------------------------------
   // Bit rate register; rate * 300 is kept alongside so the first
   // divider sees a ready-made divisor.
   // ------------------------------------------------------------------
   logic [RATE_W-1:0] rate_ff, rate_in;
   logic [D_W-1:0]    rate300_ff, rate300_in;

   always_comb begin
      rate_in    = (csr_wdata == '0) ? RATE_W'(1) : csr_wdata;
      rate300_in = D_W'(rate_in) * D_W'(EXT_DIV);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff    <= RATE_W'(1);
         rate300_ff <= D_W'(EXT_DIV);
      end else if (csr_wen) begin
         rate_ff    <= rate_in;
         rate300_ff <= rate300_in;
      end
   end

   // ------------------------------------------------------------------
   // Pipeline control: one enable for every stage, dropped only while
   // the skid register holds a result.
   // ------------------------------------------------------------------
   logic            adv;
   logic [NSTG-1:0] vld_ff;
   logic            skid_valid_ff, skid_valid_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            arrive;

   assign adv       = !skid_valid_ff;
   assign req_ready = adv;
   assign arrive    = adv && vld_ff[NSTG-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NSTG-2:0], req_valid};
      end
   end

   // ------------------------------------------------------------------
   // Front stages: add the packet offset, form two partial products
   // of the constant 216e6, then sum them into the 65-bit product.
   // ------------------------------------------------------------------
   logic [A_W-1:0]  a_ff, a_in;
   logic [LO_W-1:0] lo_ff, lo_in;
   logic [HI_W-1:0] hi_ff, hi_in;
   logic [P_W-1:0]  prod_ff, prod_in;
   logic [CC_W-1:0] cc0_ff, cc1_ff, cc2_ff;

   always_comb begin
      a_in    = A_W'(req_byte_position) + A_W'(POS_OFFSET);
      lo_in   = LO_W'(a_ff[31:0]) * LO_W'(PCR_MUL);
      hi_in   = HI_W'(a_ff[A_W-1:32]) * HI_W'(PCR_MUL);
      prod_in = P_W'(lo_ff) + {hi_ff, 32'b0};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_ff    <= a_in;
         cc0_ff  <= req_continuity_count;
         lo_ff   <= lo_in;
         hi_ff   <= hi_in;
         cc1_ff  <= cc0_ff;
         prod_ff <= prod_in;
         cc2_ff  <= cc1_ff;
      end
   end

   // ------------------------------------------------------------------
   // First divider: clock / 300 = product / (rate * 300). The quotient
   // has at most 57 bits, so the top 8 product bits seed the remainder.
   // ------------------------------------------------------------------
   div1_type div1_init;
   div1_type div1_ff [DIV1_STEPS];
   div1_type div1_in [DIV1_STEPS];

   always_comb begin
      div1_init.rem = D_W'(prod_ff[P_W-1:Q_W]);
      div1_init.dq  = prod_ff[Q_W-1:0];
      div1_init.cc  = cc2_ff;
   end

   for (genvar i = 0; i < DIV1_STEPS; i++) begin : g_div1
      div1_type         src;
      div1_type         nxt;
      logic [D_W:0]     trial;
      logic [D_W+1:0]   diff;

      if (i == 0) begin : g_first
         assign src = div1_init;
      end else begin : g_next
         assign src = div1_ff[i-1];
      end

      always_comb begin
         trial  = {src.rem, src.dq[Q_W-1]};
         diff   = {1'b0, trial} - {2'b00, rate300_ff};
         nxt.cc = src.cc;
         // borrow means trial < divisor: keep the partial remainder
         nxt.rem = diff[D_W+1] ? trial[D_W-1:0] : diff[D_W-1:0];
         nxt.dq  = {src.dq[Q_W-2:0], !diff[D_W+1]};
      end

      assign div1_in[i] = nxt;
   end

   // ------------------------------------------------------------------
   // Second divider: the remainder (< 300 * rate) divided by rate gives
   // clock % 300 in nine steps; the top 31 bits seed the remainder.
   // ------------------------------------------------------------------
   div2_type div2_init;
   div2_type div2_ff [DIV2_STEPS];
   div2_type div2_in [DIV2_STEPS];

   always_comb begin
      div2_init.rem     = div1_ff[DIV1_STEPS-1].rem[D_W-1:E_W];
      div2_init.dq      = div1_ff[DIV1_STEPS-1].rem[E_W-1:0];
      div2_init.clk_div = div1_ff[DIV1_STEPS-1].dq;
      div2_init.cc      = div1_ff[DIV1_STEPS-1].cc;
   end

   for (genvar j = 0; j < DIV2_STEPS; j++) begin : g_div2
      div2_type          src;
      div2_type          nxt;
      logic [RATE_W:0]   trial;
      logic [RATE_W+1:0] diff;

      if (j == 0) begin : g_first
         assign src = div2_init;
      end else begin : g_next
         assign src = div2_ff[j-1];
      end

      always_comb begin
         trial       = {src.rem, src.dq[E_W-1]};
         diff        = {1'b0, trial} - {2'b00, rate_ff};
         nxt.cc      = src.cc;
         nxt.clk_div = src.clk_div;
         nxt.rem     = diff[RATE_W+1] ? trial[RATE_W-1:0] : diff[RATE_W-1:0];
         nxt.dq      = {src.dq[E_W-2:0], !diff[RATE_W+1]};
      end

      assign div2_in[j] = nxt;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         div1_ff <= div1_in;
         div2_ff <= div2_in;
      end
   end

   // ------------------------------------------------------------------
   // Format the result. Since the limit is 300 * 2^33, the reduced base
   // is the low 33 bits of clock / 300 and any higher bit means a wrap.
   // ------------------------------------------------------------------
   result_type res;
   div2_type   last;

   assign last = div2_ff[DIV2_STEPS-1];

   always_comb begin
      res.clock_base      = last.clk_div[BASE_W-1:0];
      res.clock_extension = last.dq;
      res.clock_wrapped   = |last.clk_div[Q_W-1:BASE_W];
      res.packed_field    = {last.clk_div[BASE_W-1:0], RSV_BITS, last.dq};
      res.header_byte     = {ADAPT_NIBBLE, last.cc};
      res.next_continuity = last.cc + CC_STEP;
   end

   // ------------------------------------------------------------------
   // Output register plus skid register. A result arriving while the
   // output is held parks in the skid; drain the skid first.
   // ------------------------------------------------------------------
   result_type rsp_ff, rsp_in;
   result_type skid_ff, skid_in;

   always_comb begin
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (!rsp_valid_ff || rsp_ready) begin
         if (skid_valid_ff) begin
            rsp_in        = skid_ff;
            rsp_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            rsp_in       = res;
            rsp_valid_in = arrive;
         end
      end else if (arrive) begin
         skid_in       = res;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_clock_base      = rsp_ff.clock_base;
   assign rsp_clock_extension = rsp_ff.clock_extension;
   assign rsp_packed_field    = rsp_ff.packed_field;
   assign rsp_header_byte     = rsp_ff.header_byte;
   assign rsp_next_continuity = rsp_ff.next_continuity;
   assign rsp_clock_wrapped   = rsp_ff.clock_wrapped;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_skid_behind_output: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid register holds a result while the output is empty");

   a_held_arrival_parks: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready && arrive) |=> skid_valid_ff)
      else $error("result arriving at a held output was dropped");

   a_extension_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.clock_extension < EXT_DIV))
      else $error("PCR extension out of range");

   a_packed_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.packed_field[E_W-1:0] == rsp_ff.clock_extension &&
                        rsp_ff.packed_field[PF_W-1:PF_W-BASE_W] == rsp_ff.clock_base))
      else $error("packed PCR bytes disagree with base or extension");

endmodule
